>>> src/is_pkg.sv
package is_pkg;

  // One stored element, two's complement
  typedef logic signed [31:0] value_t;

  // Per-cycle command from the top level to every cell
  typedef struct packed {
    logic insert_en;  // an item is inserted this cycle
    logic shift_en;   // the chain moves one place toward cell 0 (emission)
  } cell_ctrl_t;

endpackage

>>> src/is_cell.sv
module is_cell (
  input  logic               clk,
  input  is_pkg::cell_ctrl_t ctrl,
  input  is_pkg::value_t     in_value,
  input  logic               is_occ,
  input  logic               is_tail,
  input  logic               left_greater,
  input  is_pkg::value_t     left_value,
  input  is_pkg::value_t     right_value,
  output logic               greater,
  output is_pkg::value_t     value
);

  is_pkg::value_t value_next;
  logic           take;

  // Occupied and holding a value above the new item: this cell moves up
  assign greater = is_occ && (value > in_value);

  // Every greater cell and the empty tail cell take part in the insert
  assign take = greater || is_tail;

  always_comb begin
    value_next = value;
    priority if (ctrl.shift_en) begin
      value_next = right_value;
    end else if (ctrl.insert_en && take) begin
      value_next = left_greater ? left_value : in_value;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> src/insertion_sorter.sv
// Channel   Ports                         Handshake
// --------  ----------------------------  ------------------------------------
// input     value, last                   accepted when start && !busy
// result    value_res, last_res, overflow valid for one cycle while strobe high
//
// An item not marked last is inserted; the next may start right after it.
// An item marked last is inserted, then every stored value is emitted: the chain of
// cells shifts toward cell 0 once a cycle and cell 0 is emitted, busy high.
// Each cell compares the new item against its own value, so an insert costs
// one compare per cell and no ripple along the chain.
// Reset (rst, synchronous) clears the fill count, drop flag and emission state.
// The receiver cannot stall: each result is shown for exactly one cycle.
module insertion_sorter #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    value,
  input  logic                  last,
  output logic                  strobe,
  output logic signed [31:0]    value_res,
  output logic                  last_res,
  output logic                  overflow
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam logic [FW-1:0] CAP = FW'(CAPACITY);
  localparam logic [FW-1:0] ONE = FW'(1);

  logic [FW-1:0]      fill_count;
  logic [FW-1:0]      emit_left;
  logic               dropped_flag;
  logic               accept;
  logic               full;
  is_pkg::cell_ctrl_t ctrl;

  is_pkg::value_t     cell_value   [CAPACITY];
  logic               cell_greater [CAPACITY];

  assign accept = start && !busy;
  assign full   = (fill_count == CAP);

  assign ctrl.insert_en = accept && !full;
  assign ctrl.shift_en  = busy;

  // Chain of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [FW-1:0] IDX = FW'(i);
    logic           lg;
    is_pkg::value_t lv;
    is_pkg::value_t rv;

    if (i == 0) begin : g_first
      assign lg = 1'b0;
      assign lv = cell_value[0];
    end else begin : g_mid
      assign lg = cell_greater[i-1];
      assign lv = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign rv = cell_value[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
    end

    is_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .in_value     (value),
      .is_occ       (IDX < fill_count),
      .is_tail      (IDX == fill_count),
      .left_greater (lg),
      .left_value   (lv),
      .right_value  (rv),
      .greater      (cell_greater[i]),
      .value        (cell_value[i])
    );
  end

  // Count, drop flag and emission control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      dropped_flag <= 1'b0;
      busy         <= 1'b0;
      emit_left    <= '0;
    end else if (busy) begin
      emit_left <= emit_left - ONE;
      if (emit_left == ONE) begin
        busy         <= 1'b0;
        fill_count   <= '0;
        dropped_flag <= 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        dropped_flag <= 1'b1;
      end else begin
        fill_count <= fill_count + ONE;
      end
      if (last) begin
        busy      <= 1'b1;
        emit_left <= full ? CAP : fill_count + ONE;
      end
    end
  end

  // Results come straight from cell 0, the emission counter, busy and the drop flag
  assign strobe    = busy;
  assign value_res = cell_value[0];
  assign last_res  = (emit_left == ONE);
  assign overflow  = dropped_flag;

endmodule

>>> tb/sv/insertion_sorter_tb.sv
`timescale 1ns / 100ps

module insertion_sorter_tb;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int MAX_REPORTS = 40;
  localparam is_pkg::value_t V_MIN = 32'sh8000_0000;
  localparam is_pkg::value_t V_MAX = 32'sh7fff_ffff;
  localparam is_pkg::value_t V_ONES = 32'shffff_ffff;

  // one sorted value as it leaves the block
  typedef struct packed {
    is_pkg::value_t val;
    logic   fin;
    logic   ovf;
  } sorted_t;

  // directed row: value, last flag, repeat count, typed-in expectation
  typedef struct packed {
    is_pkg::value_t v;
    logic     l;
    logic [4:0] reps;
    logic     typed;
    sorted_t  want;
  } row_t;

  localparam int N_ROWS = 11;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  is_pkg::value_t value = '0;
  logic last = 1'b0;
  logic busy;
  logic strobe;
  is_pkg::value_t value_res;
  logic last_res;
  logic overflow;

  // expected sorted values, oldest first
  sorted_t sorted_q[$];

  // private copy of the sorter state
  is_pkg::value_t shadow_store [CAPACITY];
  int      shadow_fill = 0;
  logic    shadow_dropped = 1'b0;
  sorted_t drained [CAPACITY];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int blocks_sent = 0;
  int values_checked = 0;
  int ovf_checked = 0;
  int idle_pct = 0;

  // singles first (read off directly), then a small block, then an overfull one
  row_t plan [N_ROWS] = '{
    '{V_MIN,  1'b1, 5'd1,  1'b1, '{V_MIN,  1'b1, 1'b0}},
    '{V_MAX,  1'b1, 5'd1,  1'b1, '{V_MAX,  1'b1, 1'b0}},
    '{32'sd0, 1'b1, 5'd1,  1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{V_ONES, 1'b1, 5'd1,  1'b1, '{V_ONES, 1'b1, 1'b0}},
    '{32'sd3, 1'b0, 5'd1,  1'b0, '0},
    '{V_MAX,  1'b0, 5'd1,  1'b0, '0},
    '{32'sd3, 1'b0, 5'd1,  1'b0, '0},
    '{V_MIN,  1'b1, 5'd1,  1'b0, '0},
    '{-32'sd2, 1'b0, 5'd15, 1'b0, '0},
    '{32'sd1, 1'b0, 5'd1,  1'b0, '0},
    '{32'sd40, 1'b1, 5'd1, 1'b0, '0}
  };

  insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .last(last),
    .strobe(strobe),
    .value_res(value_res),
    .last_res(last_res),
    .overflow(overflow)
  );

  always #6 clk = ~clk;

  // stable insert; on a last item drain the whole store into drained[]
  function automatic int sort_in(input is_pkg::value_t v, input logic l);
    int pos;
    int n;
    if (shadow_fill < CAPACITY) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_fill++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!l) return 0;
    n = shadow_fill;
    for (int k = 0; k < n; k++)
      drained[k] = '{shadow_store[k], (k == n - 1), shadow_dropped};
    shadow_fill = 0;
    shadow_dropped = 1'b0;
    return n;
  endfunction

  // mix of full-range, small (many duplicates) and extreme values
  function automatic is_pkg::value_t rand_value();
    case ($urandom_range(0, 3))
      0: return is_pkg::value_t'($urandom);
      1: return is_pkg::value_t'(int'($urandom_range(0, 10)) - 5);
      2: begin
        case ($urandom_range(0, 3))
          0: return V_MIN;
          1: return V_MAX;
          2: return 32'sd0;
          default: return V_ONES;
        endcase
      end
      default: return is_pkg::value_t'($urandom);
    endcase
  endfunction

  // offer one item, wait for it to be taken, record what it should produce
  task automatic push_item(input is_pkg::value_t v, input logic l, input logic typed,
                           input sorted_t want);
    int n;
    int gap;
    start <= 1'b1;
    value <= v;
    last <= l;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    n = sort_in(v, l);
    if (typed && l) begin
      sorted_q.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) sorted_q.push_back(drained[k]);
    end
    items_sent++;
    if (l) blocks_sent++;
    // sender gap, with junk on the data lines
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      value <= is_pkg::value_t'($urandom);
      last <= 1'($urandom_range(0, 1));
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  // random block: mostly short, sometimes exactly full, sometimes overfull
  task automatic push_block();
    int len;
    case ($urandom_range(0, 9))
      0: len = CAPACITY;
      1: len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      default: len = $urandom_range(1, 12);
    endcase
    for (int i = 0; i < len; i++)
      push_item(rand_value(), (i == len - 1), 1'b0, '0);
  endtask

  // compare each emitted value with the oldest expectation
  always @(posedge clk) begin : check_results
    sorted_t want;
    if (!rst && strobe === 1'b1) begin
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected: value_res=%0d last_res=%b overflow=%b",
                   $time, value_res, last_res, overflow);
      end else begin
        want = sorted_q.pop_front();
        values_checked++;
        if (want.ovf) ovf_checked++;
        if (value_res !== want.val) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: value_res expected %0d got %0d", $time, want.val, value_res);
        end
        if (last_res !== want.fin) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: last_res expected %b got %b", $time, want.fin, last_res);
        end
        if (overflow !== want.ovf) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d values still expected",
               $time, cycles, sorted_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase_start;
    int pct [4];
    pct = '{0, 71, 0, 35};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int r = 0; r < N_ROWS; r++)
      for (int j = 0; j < int'(plan[r].reps); j++)
        push_item(plan[r].v, plan[r].l && (j == int'(plan[r].reps) - 1),
                  plan[r].typed, plan[r].want);

    // random blocks under each sender idling mix
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) push_block();
    end

    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Sent %0d items in %0d blocks; checked %0d sorted values, %0d flagged overflow.",
             items_sent, blocks_sent, values_checked, ovf_checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
